@@ design/ax25_kiss_frame_builder_macros.svh @@
// Assertion macros used by the frame builder back end.
`ifndef AX25_KISS_FRAME_BUILDER_MACROS_SVH
`define AX25_KISS_FRAME_BUILDER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every rising clock edge outside reset.
`define KFB_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("frame builder check failed");

// Consequence holds in the cycle after the trigger.
`define KFB_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("frame builder sequence check failed");

`else

`define KFB_ASSERT(label, cond)
`define KFB_ASSERT_NEXT(label, trig, cons)

`endif

`endif

@@ design/kfb_pkg.sv @@
// Types, constants and header helpers for the AX.25 KISS frame builder.
package kfb_pkg;

    localparam int CALL_CHARS = 6;
    localparam int CHAR_W     = 8;
    localparam int CALL_W     = CALL_CHARS * CHAR_W;
    localparam int SSID_W     = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = CALL_W;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_DEST_CALL = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEST_SSID = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_CALL  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_SSID  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CONTROL   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PID       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_KISS_EN   = 3'd6;

    // Byte codes
    localparam logic [7:0] FLAG_BYTE  = 8'hC0;
    localparam logic [7:0] CMD_BYTE   = 8'h00;
    localparam logic [7:0] ESC_BYTE   = 8'hDB;
    localparam logic [7:0] ESC_FLAG   = 8'hDC;
    localparam logic [7:0] ESC_ESC    = 8'hDD;
    localparam logic [7:0] SSID_BASE  = 8'h60;
    localparam logic [7:0] PAD_CHAR   = 8'h20;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;
    localparam logic [7:0] CTRL_RESET = 8'h03;
    localparam logic [7:0] PID_RESET  = 8'hF0;

    // Output slots of one item, in emission order
    localparam int SLOT_W = 5;
    localparam logic [SLOT_W-1:0] SLOT_OPEN     = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_CMD      = 5'd1;
    localparam logic [SLOT_W-1:0] SLOT_HDR0     = 5'd2;
    localparam logic [SLOT_W-1:0] SLOT_HDR_LAST = 5'd17;
    localparam logic [SLOT_W-1:0] SLOT_PAYLOAD  = 5'd18;
    localparam logic [SLOT_W-1:0] SLOT_CLOSE    = 5'd19;

    // Header byte positions
    localparam int HDR_IDX_W = 4;
    localparam logic [HDR_IDX_W-1:0] HDR_DEST_SSID = 4'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_SRC0      = 4'd7;
    localparam logic [HDR_IDX_W-1:0] HDR_SRC_SSID  = 4'd13;
    localparam logic [HDR_IDX_W-1:0] HDR_CTRL      = 4'd14;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } out_item_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       hdr;
        logic       open;
        logic       close;
        logic       esc;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [CALL_W-1:0] dest_call;
        logic [SSID_W-1:0] dest_ssid;
        logic [CALL_W-1:0] src_call;
        logic [SSID_W-1:0] src_ssid;
        logic [7:0]        control_byte;
        logic [7:0]        pid_byte;
    } hdr_cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    function automatic logic [7:0] call_char(input logic [CALL_W-1:0] call,
                                             input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = call[47:40];
            3'd1:    c = call[39:32];
            3'd2:    c = call[31:24];
            3'd3:    c = call[23:16];
            3'd4:    c = call[15:8];
            3'd5:    c = call[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Pad, upper-case and shift one callsign character
    function automatic logic [7:0] fix_char(input logic [7:0] c);
        logic [7:0] u;
        if (c == 8'h00) begin
            u = PAD_CHAR;
        end else if (c >= LOWER_A && c <= LOWER_Z) begin
            u = c - CASE_DIFF;
        end else begin
            u = c;
        end
        return {u[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] hdr_byte(input hdr_cfg_t cfg,
                                            input logic [HDR_IDX_W-1:0] idx);
        logic [HDR_IDX_W-1:0] src_idx;
        logic [7:0]           b;
        src_idx = idx - HDR_SRC0;
        if (idx < HDR_DEST_SSID) begin
            b = fix_char(call_char(cfg.dest_call, idx[2:0]));
        end else if (idx == HDR_DEST_SSID) begin
            b = SSID_BASE | {3'b000, cfg.dest_ssid, 1'b0};
        end else if (idx < HDR_SRC_SSID) begin
            b = fix_char(call_char(cfg.src_call, src_idx[2:0]));
        end else if (idx == HDR_SRC_SSID) begin
            b = SSID_BASE | {3'b000, cfg.src_ssid, 1'b1};
        end else if (idx == HDR_CTRL) begin
            b = cfg.control_byte;
        end else begin
            b = cfg.pid_byte;
        end
        return b;
    endfunction

endpackage

@@ design/kfb_front.sv @@
// Front end: accepts input beats and classifies them into frame commands.
module kfb_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              kiss_en,
    input  logic              s_valid,
    output logic              s_ready,
    input  kfb_pkg::in_item_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output kfb_pkg::cmd_t     cmd_data
);

    logic          valid_reg;
    logic          valid_next;
    kfb_pkg::cmd_t cmd_reg;
    kfb_pkg::cmd_t cmd_next;
    logic          take;

    assign s_ready   = !valid_reg || cmd_ready;
    assign take      = s_valid && s_ready;
    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

    always_comb begin
        cmd_next           = cmd_reg;
        cmd_next.data_byte = s_data.data_byte;
        cmd_next.hdr       = s_data.first;
        cmd_next.open      = s_data.first && kiss_en;
        cmd_next.close     = s_data.last && kiss_en;
        cmd_next.esc       = kiss_en;
        cmd_next.last      = s_data.last;
        if (take) begin
            valid_next = 1'b1;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

@@ design/kfb_fifo.sv @@
// Two-entry command queue between front and back.
module kfb_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  kfb_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output kfb_pkg::cmd_t rd_data
);

    kfb_pkg::cmd_t                    mem_reg [kfb_pkg::FIFO_DEPTH];
    logic [kfb_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [kfb_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [kfb_pkg::FIFO_CNT_W-1:0]   count_reg;
    logic                             push;
    logic                             pop;

    assign wr_ready = count_reg != kfb_pkg::FIFO_CNT_W'(kfb_pkg::FIFO_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ design/kfb_back.sv @@
// Back end: sequences flags, header, payload and escapes into output beats.
`include "ax25_kiss_frame_builder_macros.svh"

module kfb_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  kfb_pkg::hdr_cfg_t  hdr_cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  kfb_pkg::cmd_t      cmd_data,
    output logic               m_valid,
    input  logic               m_ready,
    output kfb_pkg::out_item_t m_data
);

    kfb_pkg::state_t              state_reg;
    kfb_pkg::state_t              state_next;
    logic [kfb_pkg::SLOT_W-1:0]   slot_reg;
    logic [kfb_pkg::SLOT_W-1:0]   slot_next;
    logic                         esc_reg;
    logic                         esc_next;
    kfb_pkg::cmd_t                cmd_reg;
    logic                         load;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    kfb_pkg::out_item_t           out_reg;
    kfb_pkg::out_item_t           out_next;
    logic                         emit;
    logic                         out_free;
    logic [kfb_pkg::SLOT_W-1:0]   hdr_off;
    logic                         is_hdr;
    logic [7:0]                   raw_byte;
    logic                         escapable;
    logic                         need_esc;
    logic                         slot_done;
    logic                         finish;

    assign out_free  = !out_valid_reg || m_ready;
    assign hdr_off   = slot_reg - kfb_pkg::SLOT_HDR0;
    assign is_hdr    = slot_reg >= kfb_pkg::SLOT_HDR0 && slot_reg <= kfb_pkg::SLOT_HDR_LAST;
    assign escapable = is_hdr || slot_reg == kfb_pkg::SLOT_PAYLOAD;
    assign need_esc  = cmd_reg.esc && escapable &&
                       (raw_byte == kfb_pkg::FLAG_BYTE || raw_byte == kfb_pkg::ESC_BYTE);
    assign cmd_ready = state_reg == kfb_pkg::ST_IDLE;
    assign load      = cmd_valid && cmd_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        case (slot_reg)
            kfb_pkg::SLOT_OPEN:    raw_byte = kfb_pkg::FLAG_BYTE;
            kfb_pkg::SLOT_CMD:     raw_byte = kfb_pkg::CMD_BYTE;
            kfb_pkg::SLOT_PAYLOAD: raw_byte = cmd_reg.data_byte;
            kfb_pkg::SLOT_CLOSE:   raw_byte = kfb_pkg::FLAG_BYTE;
            default:               raw_byte = kfb_pkg::hdr_byte(hdr_cfg,
                                                hdr_off[kfb_pkg::HDR_IDX_W-1:0]);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        esc_next   = esc_reg;
        out_next   = out_reg;
        emit       = 1'b0;
        slot_done  = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            kfb_pkg::ST_IDLE: begin
                esc_next = 1'b0;
                if (load) begin
                    state_next = kfb_pkg::ST_RUN;
                    if (!cmd_data.hdr) begin
                        slot_next = kfb_pkg::SLOT_PAYLOAD;
                    end else if (cmd_data.open) begin
                        slot_next = kfb_pkg::SLOT_OPEN;
                    end else begin
                        slot_next = kfb_pkg::SLOT_HDR0;
                    end
                end
            end
            kfb_pkg::ST_RUN: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (esc_reg) begin
                        out_next.out_byte = (raw_byte == kfb_pkg::FLAG_BYTE) ?
                                            kfb_pkg::ESC_FLAG : kfb_pkg::ESC_ESC;
                        esc_next  = 1'b0;
                        slot_done = 1'b1;
                    end else if (need_esc) begin
                        out_next.out_byte = kfb_pkg::ESC_BYTE;
                        esc_next          = 1'b1;
                    end else begin
                        out_next.out_byte = raw_byte;
                        slot_done         = 1'b1;
                    end
                    if (slot_done) begin
                        if (slot_reg == kfb_pkg::SLOT_CLOSE) begin
                            finish = 1'b1;
                        end else if (slot_reg == kfb_pkg::SLOT_PAYLOAD) begin
                            if (cmd_reg.close) begin
                                slot_next = kfb_pkg::SLOT_CLOSE;
                            end else begin
                                finish = 1'b1;
                            end
                        end else begin
                            // header runs straight into the payload slot
                            slot_next = slot_reg + 1'b1;
                        end
                    end
                    if (finish) begin
                        state_next = kfb_pkg::ST_IDLE;
                    end
                    out_next.run_last  = finish;
                    out_next.frame_end = finish && cmd_reg.last;
                end
            end
            default: begin
                state_next = kfb_pkg::ST_IDLE;
            end
        endcase
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kfb_pkg::ST_IDLE;
            slot_reg      <= kfb_pkg::SLOT_OPEN;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            esc_reg       <= esc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cmd_reg <= cmd_data;
        end
        out_reg <= out_next;
    end

    `KFB_ASSERT(a_esc_only_running, !esc_reg || state_reg == kfb_pkg::ST_RUN)
    `KFB_ASSERT(a_slot_in_range,
        state_reg != kfb_pkg::ST_RUN || slot_reg <= kfb_pkg::SLOT_CLOSE)
    `KFB_ASSERT(a_end_is_run_last, !(out_valid_reg && out_reg.frame_end) || out_reg.run_last)
    `KFB_ASSERT_NEXT(a_load_starts_run, load, state_reg == kfb_pkg::ST_RUN)

endmodule

@@ design/ax25_kiss_frame_builder.sv @@
// Top level of the AX.25 UI frame builder with KISS framing.
//
//  Channel  Ports                          Beat carries
//  input    s_valid s_ready s_data         payload byte with first/last marks
//  result   m_valid m_ready m_data         framed byte, run_last, frame_end
//  config   cfg_valid cfg_ready cfg_addr   register index and write data
//           cfg_wdata
//
// The back end loads an item while idle and emits its beats; it takes no new
// item until the last beat is out. Each escape adds a beat. The sequencer
// emitting one byte per cycle, when the result port is not stalled, sets the
// rate. Reset is synchronous; no clearing pass. A stalled result port holds
// the output register; front register and two-entry queue accept until full.
module ax25_kiss_frame_builder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  kfb_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output kfb_pkg::out_item_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kfb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [kfb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    kfb_pkg::hdr_cfg_t hdr_cfg_reg;
    logic              kiss_en_reg;
    logic              cfg_wr;

    logic              fr_valid;
    logic              fr_ready;
    kfb_pkg::cmd_t     fr_data;
    logic              q_valid;
    logic              q_ready;
    kfb_pkg::cmd_t     q_data;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cfg_reg.dest_call    <= '0;
            hdr_cfg_reg.dest_ssid    <= '0;
            hdr_cfg_reg.src_call     <= '0;
            hdr_cfg_reg.src_ssid     <= '0;
            hdr_cfg_reg.control_byte <= kfb_pkg::CTRL_RESET;
            hdr_cfg_reg.pid_byte     <= kfb_pkg::PID_RESET;
            kiss_en_reg              <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_addr)
                kfb_pkg::REG_DEST_CALL: hdr_cfg_reg.dest_call <= cfg_wdata;
                kfb_pkg::REG_DEST_SSID:
                    hdr_cfg_reg.dest_ssid <= cfg_wdata[kfb_pkg::SSID_W-1:0];
                kfb_pkg::REG_SRC_CALL:  hdr_cfg_reg.src_call <= cfg_wdata;
                kfb_pkg::REG_SRC_SSID:
                    hdr_cfg_reg.src_ssid <= cfg_wdata[kfb_pkg::SSID_W-1:0];
                kfb_pkg::REG_CONTROL:   hdr_cfg_reg.control_byte <= cfg_wdata[7:0];
                kfb_pkg::REG_PID:       hdr_cfg_reg.pid_byte <= cfg_wdata[7:0];
                kfb_pkg::REG_KISS_EN:   kiss_en_reg <= cfg_wdata[0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    kfb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .kiss_en   (kiss_en_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd_data  (fr_data)
    );

    kfb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    kfb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hdr_cfg   (hdr_cfg_reg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_data  (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the AX.25 KISS frame builder: directed and random frames, checked beat by beat.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT   = 33;
    localparam int HOLD_OFF   = 200;
    localparam int SETTLE     = 8;
    localparam int STALL_MAX  = 2000;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    kfb_pkg::in_item_t              s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    kfb_pkg::out_item_t             m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [kfb_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [kfb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Mirror of the register file
    logic [kfb_pkg::CALL_W-1:0] dest_call_r;
    logic [kfb_pkg::SSID_W-1:0] dest_ssid_r;
    logic [kfb_pkg::CALL_W-1:0] src_call_r;
    logic [kfb_pkg::SSID_W-1:0] src_ssid_r;
    logic [7:0]                 ctrl_r;
    logic [7:0]                 pid_r;
    logic                       kiss_on;

    logic [7:0]         burst_bytes[$];
    kfb_pkg::out_item_t expected_frame_q[$];

    int  fail_count  = 0;
    int  stall_count = 0;
    int  hold_count  = 0;
    bit  hold_request = 1'b0;
    bit  quiet        = 1'b0;

    ax25_kiss_frame_builder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit roll_idle();
        return !quiet && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // ---------------------------------------------------------------
    // Framing predictor
    // ---------------------------------------------------------------
    function automatic void append_byte(input logic [7:0] b);
        burst_bytes = {burst_bytes, b};
    endfunction

    function automatic void push_escaped(input logic [7:0] b);
        if (kiss_on && b == kfb_pkg::FLAG_BYTE) begin
            append_byte(kfb_pkg::ESC_BYTE);
            append_byte(kfb_pkg::ESC_FLAG);
        end else if (kiss_on && b == kfb_pkg::ESC_BYTE) begin
            append_byte(kfb_pkg::ESC_BYTE);
            append_byte(kfb_pkg::ESC_ESC);
        end else begin
            append_byte(b);
        end
    endfunction

    function automatic void push_address(input logic [kfb_pkg::CALL_W-1:0] call,
                                         input logic [kfb_pkg::SSID_W-1:0] ssid,
                                         input logic is_src);
        logic [7:0] c;
        for (int i = 0; i < kfb_pkg::CALL_CHARS; i++) begin
            c = call[kfb_pkg::CHAR_W*(kfb_pkg::CALL_CHARS-1-i) +: kfb_pkg::CHAR_W];
            if (c == 8'h00)
                c = kfb_pkg::PAD_CHAR;
            else if (c >= kfb_pkg::LOWER_A && c <= kfb_pkg::LOWER_Z)
                c = c - kfb_pkg::CASE_DIFF;
            push_escaped({c[6:0], 1'b0});
        end
        push_escaped(kfb_pkg::SSID_BASE | {3'b000, ssid, is_src});
    endfunction

    function automatic void predict_framing(input kfb_pkg::in_item_t it);
        kfb_pkg::out_item_t o;
        burst_bytes.delete();
        if (it.first) begin
            if (kiss_on) begin
                append_byte(kfb_pkg::FLAG_BYTE);
                append_byte(kfb_pkg::CMD_BYTE);
            end
            push_address(dest_call_r, dest_ssid_r, 1'b0);
            push_address(src_call_r, src_ssid_r, 1'b1);
            push_escaped(ctrl_r);
            push_escaped(pid_r);
        end
        push_escaped(it.data_byte);
        if (it.last && kiss_on)
            append_byte(kfb_pkg::FLAG_BYTE);
        for (int i = 0; i < burst_bytes.size(); i++) begin
            o.out_byte  = burst_bytes[i];
            o.run_last  = (i == burst_bytes.size() - 1);
            o.frame_end = (i == burst_bytes.size() - 1) && it.last;
            expected_frame_q = {expected_frame_q, o};
        end
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input kfb_pkg::out_item_t got,
                                   input kfb_pkg::out_item_t want);
        fail_count++;
        $display("%0t: %s: got %02h/%0b/%0b, want %02h/%0b/%0b", $realtime, what,
                 got.out_byte, got.run_last, got.frame_end,
                 want.out_byte, want.run_last, want.frame_end);
    endtask

    always @(posedge aclk) begin
        kfb_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frame_q.size() == 0) begin
                report_mismatch("unexpected beat", m_data, '0);
            end else begin
                want = expected_frame_q.pop_front();
                if (m_data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", m_data, want);
                if (m_data.run_last !== want.run_last)
                    report_mismatch("run_last", m_data, want);
                if (m_data.frame_end !== want.frame_end)
                    report_mismatch("frame_end", m_data, want);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_count   = HOLD_OFF;
        end
        if (hold_count > 0) begin
            hold_count = hold_count - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !roll_idle();
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_count = 0;
            else
                stall_count = stall_count + 1;
            if (stall_count >= STALL_MAX) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic send_byte(input kfb_pkg::in_item_t it);
        @(negedge aclk);
        while (roll_idle()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_framing(it);
    endtask

    task automatic send_marked(input logic [7:0] b, input logic f, input logic l);
        kfb_pkg::in_item_t it;
        it.data_byte = b;
        it.first     = f;
        it.last      = l;
        send_byte(it);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return kfb_pkg::FLAG_BYTE;
            1:       return kfb_pkg::ESC_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_marked(pick_byte(), i == 0, i == len - 1);
    endtask

    // Wait until every expected beat is out and the block is quiet
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_frame_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [kfb_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [kfb_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            kfb_pkg::REG_DEST_CALL: dest_call_r = val[kfb_pkg::CALL_W-1:0];
            kfb_pkg::REG_DEST_SSID: dest_ssid_r = val[kfb_pkg::SSID_W-1:0];
            kfb_pkg::REG_SRC_CALL:  src_call_r  = val[kfb_pkg::CALL_W-1:0];
            kfb_pkg::REG_SRC_SSID:  src_ssid_r  = val[kfb_pkg::SSID_W-1:0];
            kfb_pkg::REG_CONTROL:   ctrl_r      = val[7:0];
            kfb_pkg::REG_PID:       pid_r       = val[7:0];
            kfb_pkg::REG_KISS_EN:   kiss_on     = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [kfb_pkg::CFG_DATA_W-1:0] rand_word();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [kfb_pkg::CALL_W-1:0] rand_call();
        logic [kfb_pkg::CALL_W-1:0] call;
        logic [7:0]                 c;
        for (int i = 0; i < kfb_pkg::CALL_CHARS; i++) begin
            case ($urandom_range(6))
                0:       c = 8'h00;
                1:       c = 8'($urandom_range(8'h61, 8'h7A));
                2:       c = 8'($urandom_range(8'h41, 8'h5A));
                3:       c = 8'($urandom_range(8'h30, 8'h39));
                4:       c = ($urandom_range(1) != 0) ? 8'h60 : 8'hE0;
                default: c = 8'($urandom_range(255));
            endcase
            call[kfb_pkg::CHAR_W*i +: kfb_pkg::CHAR_W] = c;
        end
        return call;
    endfunction

    task automatic randomise_config();
        settle();
        write_reg(kfb_pkg::REG_DEST_CALL,
                  ($urandom_range(7) == 0) ? {kfb_pkg::CFG_DATA_W{1'b1}} : rand_call());
        write_reg(kfb_pkg::REG_DEST_SSID, rand_word());
        write_reg(kfb_pkg::REG_SRC_CALL,  ($urandom_range(7) == 0) ? '0 : rand_call());
        write_reg(kfb_pkg::REG_SRC_SSID,  rand_word());
        write_reg(kfb_pkg::REG_CONTROL,
                  ($urandom_range(3) == 0) ? kfb_pkg::FLAG_BYTE : rand_word());
        write_reg(kfb_pkg::REG_PID,
                  ($urandom_range(3) == 0) ? kfb_pkg::ESC_BYTE : rand_word());
        write_reg(kfb_pkg::REG_KISS_EN,
                  ($urandom_range(3) == 0) ? '0 : rand_word() | 48'd1);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_reset_header();
        send_marked(8'h00, 1'b1, 1'b1);
        send_marked(8'hFF, 1'b1, 1'b0);
        send_marked(kfb_pkg::FLAG_BYTE, 1'b0, 1'b1);
    endtask

    task automatic test_marks_out_of_order();
        send_marked(kfb_pkg::ESC_BYTE, 1'b0, 1'b0);
        send_marked(8'h55, 1'b1, 1'b0);
        send_marked(8'hAA, 1'b1, 1'b0);
        send_marked(kfb_pkg::ESC_ESC, 1'b0, 1'b1);
        send_marked(kfb_pkg::ESC_FLAG, 1'b0, 1'b1);
    endtask

    // Lower case, out-of-range letters and characters that shift onto the flag
    task automatic test_header_escapes();
        settle();
        write_reg(kfb_pkg::REG_DEST_CALL, 48'h61_62_7A_60_7B_40);
        write_reg(kfb_pkg::REG_DEST_SSID, 48'd15);
        write_reg(kfb_pkg::REG_SRC_CALL,  48'hE0_6D_00_FF_00_00);
        write_reg(kfb_pkg::REG_SRC_SSID,  48'd0);
        write_reg(kfb_pkg::REG_CONTROL,   kfb_pkg::FLAG_BYTE);
        write_reg(kfb_pkg::REG_PID,       kfb_pkg::ESC_BYTE);
        send_marked(kfb_pkg::FLAG_BYTE, 1'b1, 1'b0);
        send_marked(kfb_pkg::ESC_BYTE, 1'b0, 1'b0);
        send_marked(8'h00, 1'b0, 1'b0);
        send_marked(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_kiss_off();
        settle();
        write_reg(kfb_pkg::REG_KISS_EN,   48'd0);
        write_reg(kfb_pkg::REG_DEST_CALL, {kfb_pkg::CFG_DATA_W{1'b1}});
        write_reg(kfb_pkg::REG_SRC_CALL,  48'd0);
        write_reg(kfb_pkg::REG_SRC_SSID,  48'd15);
        write_reg(kfb_pkg::REG_CONTROL,   48'd0);
        write_reg(kfb_pkg::REG_PID,       48'hFF);
        send_marked(kfb_pkg::FLAG_BYTE, 1'b1, 1'b0);
        send_marked(kfb_pkg::ESC_BYTE, 1'b0, 1'b1);
        send_marked(8'h7E, 1'b1, 1'b1);
        send_marked(8'h01, 1'b0, 1'b1);
        settle();
        write_reg(kfb_pkg::REG_KISS_EN, 48'd1);
    endtask

    task automatic run_random_phase(input int n_items);
        int sent;
        int len;
        sent = 0;
        randomise_config();
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                // stray item with arbitrary marks
                send_marked(8'($urandom_range(255)), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
                sent++;
            end else begin
                len = ($urandom_range(3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
                send_frame(len);
                sent += len;
            end
        end
    endtask

    task automatic test_random_frames();
        for (int p = 0; p < 5; p++)
            run_random_phase(50);
    endtask

    // Hold the result port while frames keep coming so the input stalls
    task automatic test_backpressure();
        settle();
        hold_request = 1'b1;
        for (int i = 0; i < 5; i++)
            send_frame(5);
    endtask

    task automatic test_no_idling();
        settle();
        quiet = 1'b1;
        for (int i = 0; i < 5; i++)
            send_frame(4);
        settle();
        quiet = 1'b0;
    endtask

    initial begin
        dest_call_r = '0;
        dest_ssid_r = '0;
        src_call_r  = '0;
        src_ssid_r  = '0;
        ctrl_r      = kfb_pkg::CTRL_RESET;
        pid_r       = kfb_pkg::PID_RESET;
        kiss_on     = 1'b1;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_header();
        test_marks_out_of_order();
        test_header_escapes();
        test_kiss_off();
        test_random_frames();
        test_backpressure();
        test_no_idling();

        settle();
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
